FILE: hdl/mbce_pkg.sv
package mbce_pkg;

  // Request kinds carried in req_type
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CLIP_X      = 3'd0,
    REG_CLIP_Y      = 3'd1,
    REG_CLIP_W      = 3'd2,
    REG_CLIP_H      = 3'd3,
    REG_FORE_COLOUR = 3'd4,
    REG_BACK_COLOUR = 3'd5,
    REG_ROTATION    = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 24;
  localparam logic [23:0] BackColourReset = 24'hFFFFFF;

  // Rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] image_x;
    logic signed [15:0] image_y;
    logic [14:0]        bitmap_w;
    logic [14:0]        bitmap_h;
    logic [7:0]         data_byte;
  } req_t;

  typedef struct packed {
    logic signed [15:0] panel_x;
    logic signed [15:0] panel_y;
    logic [23:0]        wr_colour;
    logic               last_of_byte;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [14:0]        clip_w;
    logic [14:0]        clip_h;
    logic [23:0]        fore_colour;
    logic [23:0]        back_colour;
    logic [1:0]         rotation;
  } cfg_t;

  // One data byte ready for expansion: visible pixels and their base position
  typedef struct packed {
    logic [7:0]         mask;
    logic [7:0]         data;
    logic signed [17:0] lx0;
    logic signed [17:0] ly;
  } job_t;

endpackage

FILE: hdl/mbce_cfg.sv
module mbce_cfg
  import mbce_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CLIP_X:      cfg_d.clip_x      = $signed(cfg_wdata_i[15:0]);
        REG_CLIP_Y:      cfg_d.clip_y      = $signed(cfg_wdata_i[15:0]);
        REG_CLIP_W:      cfg_d.clip_w      = cfg_wdata_i[14:0];
        REG_CLIP_H:      cfg_d.clip_h      = cfg_wdata_i[14:0];
        REG_FORE_COLOUR: cfg_d.fore_colour = cfg_wdata_i;
        REG_BACK_COLOUR: cfg_d.back_colour = cfg_wdata_i;
        REG_ROTATION:    cfg_d.rotation    = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q             <= '0;
      cfg_q.back_colour <= BackColourReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/mbce_front.sv
module mbce_front
  import mbce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output job_t job_o
);

  logic signed [15:0] origin_x_q, origin_y_q;
  logic [14:0]        width_q, height_q;
  logic [11:0]        byte_col_q;
  logic [14:0]        row_q;
  logic               active_q;

  logic signed [15:0] origin_x_d, origin_y_d;
  logic [14:0]        width_d, height_d;
  logic [11:0]        byte_col_d;
  logic [14:0]        row_d;
  logic               active_d;

  logic signed [17:0] cx0, cx1, cy0, cy1, lx0, ly;
  logic               row_in;
  logic [7:0]         vis;
  logic [12:0]        bytes_per_row;
  logic [11:0]        col_inc;
  logic [14:0]        row_inc;

  always_comb begin
    logic [14:0]        col_b;
    logic signed [17:0] lx_b;
    cx0    = 18'(cfg_i.clip_x);
    cy0    = 18'(cfg_i.clip_y);
    cx1    = cx0 + $signed({3'b000, cfg_i.clip_w});
    cy1    = cy0 + $signed({3'b000, cfg_i.clip_h});
    lx0    = 18'(origin_x_q) + $signed({3'b000, byte_col_q, 3'b000});
    ly     = 18'(origin_y_q) + $signed({3'b000, row_q});
    row_in = (ly >= cy0) && (ly < cy1);
    for (int b = 0; b < 8; b++) begin
      col_b  = {byte_col_q, 3'(b)};
      lx_b   = lx0 + $signed({15'd0, 3'(b)});
      vis[b] = (col_b < width_q) && row_in && (lx_b >= cx0) && (lx_b < cx1);
    end
  end

  assign bytes_per_row = 13'((16'(width_q) + 16'd7) >> 3);
  assign col_inc       = byte_col_q + 12'd1;
  assign row_inc       = row_q + 15'd1;

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    width_d    = width_q;
    height_d   = height_q;
    byte_col_d = byte_col_q;
    row_d      = row_q;
    active_d   = active_q;
    if (in_fire_i) begin
      if (req_i.req_type == REQ_START) begin
        origin_x_d = req_i.image_x;
        origin_y_d = req_i.image_y;
        width_d    = req_i.bitmap_w;
        height_d   = req_i.bitmap_h;
        byte_col_d = '0;
        row_d      = '0;
        active_d   = (req_i.bitmap_w != '0) && (req_i.bitmap_h != '0);
      end else if (active_q) begin
        byte_col_d = col_inc;
        // wrap to the next row at the end of a row
        if ((13'(col_inc) >= bytes_per_row) || (col_inc == '0)) begin
          byte_col_d = '0;
          row_d      = row_inc;
          if ((row_inc >= height_q) || (row_inc == '0)) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      byte_col_q <= '0;
      row_q      <= '0;
      active_q   <= 1'b0;
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      width_q    <= width_d;
      height_q   <= height_d;
      byte_col_q <= byte_col_d;
      row_q      <= row_d;
      active_q   <= active_d;
    end
  end

  always_comb begin
    job_o.mask = ((req_i.req_type == REQ_DATA) && active_q) ? vis : 8'd0;
    job_o.data = req_i.data_byte;
    job_o.lx0  = lx0;
    job_o.ly   = ly;
  end

endmodule

FILE: hdl/mbce_emit.sv
module mbce_emit
  import mbce_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  job_t job_i,
  input  cfg_t cfg_i,
  output logic job_free_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam logic signed [17:0] PwM1 = 18'(PANEL_WIDTH - 1);
  localparam logic signed [17:0] PhM1 = 18'(PANEL_HEIGHT - 1);

  logic [7:0]         mask_q, mask_d;
  logic [7:0]         data_q;
  logic signed [17:0] lx0_q, ly_q;
  logic               out_valid_q, out_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic [2:0]         sel;
  logic [7:0]         rest;
  logic               emit_fire;
  logic signed [17:0] lx, px, py;

  // lowest pending column goes first
  always_comb begin
    sel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (mask_q[b]) sel = 3'(b);
    end
  end

  assign rest       = mask_q & ~(8'd1 << sel);
  assign emit_fire  = (mask_q != '0) && (!out_valid_q || !out_stall_i);
  assign job_free_o = (mask_q == '0) || (emit_fire && (rest == '0));
  assign lx         = lx0_q + $signed({15'd0, sel});

  always_comb begin
    case (cfg_i.rotation)
      ROT_90: begin
        px = ly_q;
        py = PhM1 - lx;
      end
      ROT_180: begin
        px = PwM1 - lx;
        py = PhM1 - ly_q;
      end
      ROT_270: begin
        px = PwM1 - ly_q;
        py = lx;
      end
      default: begin
        px = lx;
        py = ly_q;
      end
    endcase
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = job_i.mask;
    end else if (emit_fire) begin
      mask_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (emit_fire) begin
      out_valid_d        = 1'b1;
      rsp_d.panel_x      = px[15:0];
      rsp_d.panel_y      = py[15:0];
      rsp_d.wr_colour    = data_q[3'd7 - sel] ? cfg_i.back_colour : cfg_i.fore_colour;
      rsp_d.last_of_byte = (rest == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= job_i.data;
      lx0_q  <= job_i.lx0;
      ly_q   <= job_i.ly;
    end
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

FILE: hdl/mono_bitmap_clip_expand_unit.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  in_req_i  (req_t)
// result    out        out_valid_o / out_stall_i out_rsp_o (rsp_t)
// config    in         cfg_we_i, cfg_idx_i      cfg_wdata_i
//
// A request is taken while the serialiser is free; its visible pixels then leave
// one per cycle while the result side is not stalled, so a data byte occupies the
// pixel serialiser until its last visible pixel has been handed out, and a start or
// an invisible byte passes through without occupying it.
// Reset is asynchronous and active low; it clears the bitmap counters, the pending
// pixel mask, the output valid and the configuration registers to their defaults.
// A stall on the result side holds the output register; requests keep flowing
// until the serialiser holds a byte with pixels still to send.
module mono_bitmap_clip_expand_unit
  import mbce_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  req_t                    in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output rsp_t                    out_rsp_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  cfg_t cfg;
  job_t job;
  logic job_free;
  logic in_fire;

  // a request is taken only when the serialiser can take its pixels
  assign in_stall_o = !job_free;
  assign in_fire    = in_valid_i && job_free;

  // configuration registers
  mbce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // bitmap counters and per-byte clip mask
  mbce_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .req_i     (in_req_i),
    .cfg_i     (cfg),
    .job_o     (job)
  );

  // pixel serialiser, rotation and output register
  mbce_emit #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .job_i       (job),
    .cfg_i       (cfg),
    .job_free_o  (job_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: hdl/mbce_checker.sv
module mbce_checker
  import mbce_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input rsp_t out_rsp_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // pixels of one byte follow back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_rsp_o.last_of_byte |=> out_valid_o)
    else $error("gap inside a byte's pixels");

  // while a stalled byte is only part sent, no new request may enter
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !out_rsp_o.last_of_byte |-> in_stall_o)
    else $error("request taken mid byte");

  // reset empties the output by the next edge
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind mono_bitmap_clip_expand_unit mbce_checker u_mbce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_rsp_o   (out_rsp_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
